[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the buddy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int WORD_W   = 32;
  localparam int WORD_LSB = 5;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_OOM = 2'd2
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                found;
    logic [WORD_LSB-1:0] bsel;
  } bba_hit_t;

endpackage

`default_nettype wire

[rtl/bba_ram.sv]
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/bba_scan.sv]
// ----------------------------------------------------------------------------
// bba_scan
// Lowest set free bit of one memory word inside a level's position window.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_scan #(
  parameter int POSW = 11
) (
  input  wire logic [bba_pkg::WORD_W-1:0]          word_i,
  input  wire logic [POSW-bba_pkg::WORD_LSB-1:0]   waddr_i,
  input  wire logic [POSW-1:0]                     lo_i,
  input  wire logic [POSW-1:0]                     hi_i,
  output bba_pkg::bba_hit_t                        hit_o
);
  import bba_pkg::*;

  logic [WORD_W-1:0] mask;
  logic [POSW-1:0]   pos [WORD_W];

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      pos[b]  = {waddr_i, WORD_LSB'(b)};
      mask[b] = word_i[b] && (pos[b] >= lo_i) && (pos[b] < hi_i);
    end
  end

  always_comb begin
    hit_o.found = |mask;
    hit_o.bsel  = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (mask[b]) begin
        hit_o.bsel = WORD_LSB'(b);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/buddy_block_allocator_core.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Binary buddy allocator; free bits of all orders live in one word RAM.
// ----------------------------------------------------------------------------
// Steps: a bad size goes straight to the response; allocate scans 32-bit words
//   for a free bit, then splits down to the order; free merges order by order.
// Throughput: one request at a time, set by the single RAM read-modify-write.
// Reset: a clearing pass over the 2^(POOL_ORDER+1)/32 RAM words (64 by default,
//   at least 2) initializes the RAM; no request is taken until it ends.
`default_nettype none

module buddy_block_allocator_core #(
  parameter int POOL_ORDER  = 10,
  parameter int BLOCK_BYTES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [22:0] size_bytes_i,
  input  wire logic [9:0]  block_offset_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [1:0]  status_o,
  output logic      [9:0]  granted_offset_o,
  output logic      [3:0]  granted_order_o
);
  import bba_pkg::*;

  localparam int TWO_P1     = 2 ** (POOL_ORDER + 1);
  localparam int NWORDS_RAW = (TWO_P1 + WORD_W - 1) / WORD_W;
  localparam int NWORDS     = (NWORDS_RAW < 2) ? 2 : NWORDS_RAW;
  localparam int AW         = $clog2(NWORDS);
  localparam int POSW       = AW + WORD_LSB;
  localparam int IW         = POOL_ORDER;
  localparam int FC         = TWO_P1 - 2;
  localparam logic [63:0] HALF = 64'(BLOCK_BYTES) << (POOL_ORDER - 1);
  localparam logic [3:0]  TOP  = 4'(POOL_ORDER - 1);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_SRD    = 9'b000000100,
    S_SCHK   = 9'b000001000,
    S_SPL_RD = 9'b000010000,
    S_SPL_WR = 9'b000100000,
    S_FRD    = 9'b001000000,
    S_FWR    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  function automatic logic [POSW-1:0] lvl_base(input logic [3:0] j);
    lvl_base = POSW'(TWO_P1 - (1 << (POOL_ORDER + 1 - int'(j))));
  endfunction

  function automatic logic [POSW-1:0] lvl_end(input logic [3:0] j);
    lvl_end = POSW'(TWO_P1 - (1 << (POOL_ORDER - int'(j))));
  endfunction

  state_e        state_q, state_d;
  logic [3:0]    k_q, k_d, j_q, j_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [AW-1:0] wa_q, wa_d, clr_q, clr_d;
  logic          cmd_q, cmd_d;
  status_e       st_q, st_d;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_status_q, out_status_d;
  logic [9:0]    out_off_q, out_off_d;
  logic [3:0]    out_order_q, out_order_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata, init_word;

  logic [63:0]       sz64;
  logic              bad;
  logic [3:0]        k_dec;
  logic [IW-1:0]     fpos;
  logic [POSW-1:0]   lo, hi, hit_pos, pos_s, pos_f, base_k, base_up;
  logic [POSW:0]     nxt_start;
  logic [WORD_LSB-1:0] fb;
  logic [31:0]       off_full;
  bba_hit_t          hit;

  bba_ram #(.WIDTH(WORD_W), .DEPTH(NWORDS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign lo = lvl_base(j_q);
  assign hi = lvl_end(j_q);

  bba_scan #(.POSW(POSW)) u_scan (
    .word_i (ram_rdata),
    .waddr_i(wa_q),
    .lo_i   (lo),
    .hi_i   (hi),
    .hit_o  (hit)
  );

  always_comb begin
    sz64  = 64'(size_bytes_i);
    bad   = (size_bytes_i == '0) || (sz64 > HALF);
    k_dec = TOP;
    for (int i = POOL_ORDER - 2; i >= 0; i--) begin
      if (sz64 <= (64'(BLOCK_BYTES) << i)) begin
        k_dec = 4'(i);
      end
    end
    fpos = IW'(block_offset_i);
  end

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      init_word[b] = ({clr_q, WORD_LSB'(b)} == POSW'(FC - 2)) ||
                     ({clr_q, WORD_LSB'(b)} == POSW'(FC - 1));
    end
  end

  assign base_k    = lvl_base(k_dec);
  assign base_up   = lvl_base(j_q + 4'd1);
  assign hit_pos   = {wa_q, hit.bsel};
  assign nxt_start = {1'b0, wa_q, {WORD_LSB{1'b0}}} + (POSW + 1)'(WORD_W);
  assign pos_s     = lvl_base(j_q) + POSW'(idx_q) + POSW'(1);
  assign pos_f     = lvl_base(j_q) + POSW'(idx_q);
  assign fb        = pos_f[WORD_LSB-1:0];
  assign off_full  = 32'(idx_q) << k_q;

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    j_d          = j_q;
    idx_d        = idx_q;
    wa_d         = wa_q;
    clr_d        = clr_q;
    cmd_d        = cmd_q;
    st_d         = st_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_off_d    = out_off_q;
    out_order_d  = out_order_q;
    ram_we       = 1'b0;
    ram_waddr    = wa_q;
    ram_wdata    = ram_rdata;
    ram_raddr    = wa_q;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = init_word;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(NWORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = command_i;
          k_d   = k_dec;
          j_d   = k_dec;
          if (bad) begin
            st_d    = ST_BAD;
            state_d = S_DONE;
          end else if (command_i == CMD_ALLOC) begin
            st_d    = ST_OK;
            wa_d    = base_k[POSW-1:WORD_LSB];
            state_d = S_SRD;
          end else begin
            st_d    = ST_OK;
            idx_d   = fpos >> k_dec;
            state_d = S_FRD;
          end
        end
      end
      S_SRD: begin
        state_d = S_SCHK;
      end
      S_SCHK: begin
        if (hit.found) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~(WORD_W'(1) << hit.bsel);
          idx_d     = IW'(hit_pos - lo);
          if (j_q > k_q) begin
            j_d     = j_q - 4'd1;
            idx_d   = IW'(hit_pos - lo) << 1;
            state_d = S_SPL_RD;
          end else begin
            state_d = S_DONE;
          end
        end else if (nxt_start >= {1'b0, hi}) begin
          if (j_q == TOP) begin
            st_d    = ST_OOM;
            state_d = S_DONE;
          end else begin
            j_d     = j_q + 4'd1;
            wa_d    = base_up[POSW-1:WORD_LSB];
            state_d = S_SRD;
          end
        end else begin
          wa_d    = wa_q + AW'(1);
          state_d = S_SRD;
        end
      end
      S_SPL_RD: begin
        ram_raddr = pos_s[POSW-1:WORD_LSB];
        state_d   = S_SPL_WR;
      end
      S_SPL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_s[POSW-1:WORD_LSB];
        ram_wdata = ram_rdata | (WORD_W'(1) << pos_s[WORD_LSB-1:0]);
        if (j_q > k_q) begin
          j_d     = j_q - 4'd1;
          idx_d   = idx_q << 1;
          state_d = S_SPL_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FRD: begin
        ram_raddr = pos_f[POSW-1:WORD_LSB];
        state_d   = S_FWR;
      end
      S_FWR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_f[POSW-1:WORD_LSB];
        if ((j_q != TOP) && ram_rdata[fb ^ WORD_LSB'(1)]) begin
          ram_wdata = ram_rdata & ~(WORD_W'(1) << fb) & ~(WORD_W'(1) << (fb ^ WORD_LSB'(1)));
          j_d       = j_q + 4'd1;
          idx_d     = idx_q >> 1;
          state_d   = S_FRD;
        end else begin
          ram_wdata = ram_rdata | (WORD_W'(1) << fb);
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = st_q;
          out_order_d  = (st_q == ST_BAD) ? 4'd0 : k_q;
          out_off_d    = ((st_q == ST_OK) && (cmd_q == CMD_ALLOC)) ? off_full[9:0] : 10'd0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
      st_q         <= ST_OK;
      cmd_q        <= 1'b0;
      k_q          <= '0;
      j_q          <= '0;
      idx_q        <= '0;
      wa_q         <= '0;
      out_status_q <= '0;
      out_off_q    <= '0;
      out_order_q  <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      out_valid_q  <= out_valid_d;
      st_q         <= st_d;
      cmd_q        <= cmd_d;
      k_q          <= k_d;
      j_q          <= j_d;
      idx_q        <= idx_d;
      wa_q         <= wa_d;
      out_status_q <= out_status_d;
      out_off_q    <= out_off_d;
      out_order_q  <= out_order_d;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign granted_offset_o = out_off_q;
  assign granted_order_o  = out_order_q;

endmodule

`default_nettype wire

[rtl/bba_checker.sv]
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the buddy block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] status_o,
  input wire logic [9:0] granted_offset_o,
  input wire logic [3:0] granted_order_o
);
  import bba_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(granted_offset_o) && $stable(granted_order_o))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one in flight");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_BAD) |-> (granted_order_o == 4'd0) &&
    (granted_offset_o == 10'd0))
    else $error("bad size beat carries order or offset");

  a_fail_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (granted_offset_o == 10'd0))
    else $error("failed request reports an offset");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .granted_offset_o(granted_offset_o),
  .granted_order_o (granted_order_o)
);

`default_nettype wire

[test/buddy_block_allocator_core_test.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator_core_test
// Drives allocate and free requests into the buddy allocator, predicts each
// response with a local model of the free bits, and checks every field.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator_core_test;
  import bba_pkg::*;

  localparam int PORD = 10;
  localparam int TOPO = PORD - 1;
  localparam int NFLAG = (1 << (PORD + 1)) - 2;
  localparam longint HALF_BYTES = longint'(4096) << TOPO;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    status_e    status;
    logic [9:0] offset;
    logic [3:0] order;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        command_i = 1'b0;
  logic [22:0] size_bytes_i = '0;
  logic [9:0]  block_offset_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [9:0]  granted_offset_o;
  logic [3:0]  granted_order_o;

  buddy_block_allocator_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .size_bytes_i,
    .block_offset_i, .out_valid_o, .out_stall_i, .status_o, .granted_offset_o,
    .granted_order_o
  );

  always #5 clk_i = ~clk_i;

  bit     free_map[NFLAG];
  grant_t grant_q[$];
  int     err_cnt = 0;
  int     idle_cnt = 0;
  int     send_idle = 0;
  int     recv_stall = 0;
  int     live_off[$];
  int     live_ord[$];

  function automatic int lvl_base(int k);
    return (1 << (PORD + 1)) - (1 << (PORD + 1 - k));
  endfunction

  function automatic bit map_get(int k, int i);
    int p;
    p = lvl_base(k) + i;
    return p < NFLAG && free_map[p];
  endfunction

  function automatic void map_put(int k, int i, bit v);
    int p;
    p = lvl_base(k) + i;
    if (p < NFLAG) free_map[p] = v;
  endfunction

  function automatic void map_reset();
    foreach (free_map[i]) free_map[i] = 1'b0;
    map_put(TOPO, 0, 1'b1);
    map_put(TOPO, 1, 1'b1);
  endfunction

  function automatic grant_t predict_grant(cmd_e cmd, logic [22:0] sz, logic [9:0] boff);
    grant_t g;
    int k, j, idx, n;
    bit hit;
    k = 0;
    g = '{ST_OK, 10'd0, 4'd0};
    if (sz == 0 || longint'(sz) > HALF_BYTES) begin
      g.status = ST_BAD;
      return g;
    end
    while (k < TOPO && (longint'(4096) << k) < longint'(sz)) k++;
    g.order = k[3:0];
    if (cmd == CMD_ALLOC) begin
      j = k;
      hit = 1'b0;
      idx = 0;
      while (j <= TOPO && !hit) begin
        n = 1 << (PORD - j);
        for (idx = 0; idx < n; idx++) if (map_get(j, idx)) break;
        if (idx < n) hit = 1'b1;
        else j++;
      end
      if (!hit) g.status = ST_OOM;
      else begin
        map_put(j, idx, 1'b0);
        while (j > k) begin
          j--;
          idx = idx << 1;
          map_put(j, idx + 1, 1'b1);
        end
        g.offset = 10'((idx << k) & 'h3FF);
      end
    end else begin
      idx = int'(boff) >> k;
      j = k;
      map_put(j, idx, 1'b1);
      while (j < TOPO && map_get(j, idx ^ 1)) begin
        map_put(j, idx, 1'b0);
        map_put(j, idx ^ 1, 1'b0);
        j++;
        idx = idx >> 1;
        map_put(j, idx, 1'b1);
      end
    end
    return g;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  task automatic send_beat(cmd_e cmd, logic [22:0] sz, logic [9:0] boff);
    grant_t g;
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    size_bytes_i <= sz;
    block_offset_i <= boff;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    g = predict_grant(cmd, sz, boff);
    grant_q.push_back(g);
    if (cmd == CMD_ALLOC && g.status == ST_OK) begin
      live_off.push_back(g.offset);
      live_ord.push_back(g.order);
    end
    @(negedge clk_i);
  endtask

  always @(negedge clk_i)
    out_stall_i <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);

  always @(posedge clk_i) begin
    grant_t g;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (grant_q.size() == 0) report_mismatch("unexpected beat", 1, 0);
      else begin
        g = grant_q.pop_front();
        if (status_o != g.status) report_mismatch("status", status_o, g.status);
        if (granted_offset_o != g.offset)
          report_mismatch("granted_offset", granted_offset_o, g.offset);
        if (granted_order_o != g.order)
          report_mismatch("granted_order", granted_order_o, g.order);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [22:0] order_bytes(int k);
    return 23'((4096 << k) - $urandom_range(4095));
  endfunction

  task automatic free_random_region();
    int i;
    i = $urandom_range(live_off.size() - 1);
    send_beat(CMD_FREE, order_bytes(live_ord[i]), 10'(live_off[i]));
    live_off.delete(i);
    live_ord.delete(i);
  endtask

  task automatic test_directed();
    send_beat(CMD_ALLOC, 23'd0, 10'd0);
    send_beat(CMD_FREE, 23'd0, 10'd5);
    send_beat(CMD_ALLOC, 23'(HALF_BYTES + 1), 10'd0);
    send_beat(CMD_ALLOC, 23'h7FFFFF, 10'h3FF);
    send_beat(CMD_FREE, 23'h400000, 10'd0);
    send_beat(CMD_ALLOC, 23'd1, 10'd0);
    send_beat(CMD_ALLOC, 23'd4096, 10'd0);
    send_beat(CMD_ALLOC, 23'd4097, 10'd0);
    send_beat(CMD_ALLOC, 23'(HALF_BYTES), 10'd0);
    send_beat(CMD_ALLOC, 23'(HALF_BYTES), 10'd0);
    send_beat(CMD_ALLOC, 23'(HALF_BYTES), 10'd0);
    send_beat(CMD_FREE, 23'd100, 10'd1);
    send_beat(CMD_FREE, 23'd100, 10'd1);
    send_beat(CMD_FREE, 23'd9000, 10'h3FF);
    send_beat(CMD_FREE, 23'(HALF_BYTES), 10'h3FF);
    send_beat(CMD_FREE, 23'(HALF_BYTES), 10'h000);
    send_beat(CMD_FREE, 23'd4096, 10'd0);
    live_off.delete();
    live_ord.delete();
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) send_beat(CMD_ALLOC, order_bytes($urandom_range(TOPO)), 10'($urandom));
      else if (r < 85 && live_off.size() > 0) free_random_region();
      else send_beat(cmd_e'($urandom_range(1)), 23'($urandom), 10'($urandom));
    end
  endtask

  task automatic test_phase(int si, int rs, int n);
    send_idle = si;
    recv_stall = rs;
    test_random(n);
  endtask

  initial begin
    map_reset();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_phase(0, 0, 340);
    test_phase(63, 0, 330);
    test_phase(0, 63, 330);
    test_phase(18, 18, 330);
    in_valid_i <= 1'b0;
    send_idle = 0;
    recv_stall = 0;
    while (grant_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
